### src/sobel_pkg.sv
// shared types and constants for the sobel edge magnitude block
`timescale 1ns / 1ps
`default_nettype none
package sobel_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 11;
  localparam int ROW_W     = 17;
  localparam int HGT_W     = 16;
  localparam int PIX_W     = 24;
  localparam int GRAD_W    = 12;
  localparam int SUM_W     = 21;
  localparam int SQ_W      = 16;
  localparam int SQ_LIMIT  = 65280;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // register indexes on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } sobel_in_t;

  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_end;
  } sobel_out_t;

  typedef struct packed {
    logic [COL_W-1:0] image_width;
    logic [HGT_W-1:0] image_height;
    logic             restart;
  } sobel_cfg_t;

  typedef struct packed {
    logic            done;
    logic [2:0][7:0] mag;
  } sobel_sqrt_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQ,
    S_SQRT,
    S_PUSH
  } sobel_state_t;

endpackage
`default_nettype wire

### src/sobel_line_ram.sv
// generic single-port-write, registered-read ram for the line stores
`timescale 1ns / 1ps
`default_nettype none
module sobel_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/sobel_cfg.sv
// apb register file for image width and height
`timescale 1ns / 1ps
`default_nettype none
module sobel_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output sobel_pkg::sobel_cfg_t   cfg
);
  import sobel_pkg::*;

  logic [COL_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic             restart;
  logic             wr;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  // any write restarts the frame at the same edge
  assign restart = wr;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= COL_W'(WIDTH_RESET);
      image_height <= HGT_W'(HEIGHT_RESET);
    end else begin
      if (wr) begin
        if (paddr[2] == REG_HEIGHT) begin
          image_height <= pwdata[HGT_W-1:0];
        end else begin
          image_width <= pwdata[COL_W-1:0];
        end
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == REG_HEIGHT) begin
      prdata = {{(32-HGT_W){1'b0}}, image_height};
    end else begin
      prdata = {{(32-COL_W){1'b0}}, image_width};
    end
  end

  assign cfg = '{image_width: image_width, image_height: image_height, restart: restart};

endmodule
`default_nettype wire

### src/sobel_sqrt.sv
// iterative rounded square root, three channels side by side, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sobel_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [2:0][sobel_pkg::SUM_W-1:0] sum,
  output sobel_pkg::sobel_sqrt_res_t       res
);
  import sobel_pkg::*;

  logic [2:0][SQ_W-1:0] sv;
  logic [2:0]           sat;
  logic [2:0][7:0]      r;
  logic [2:0][7:0]      r_next;
  logic [2:0][7:0]      mag;
  logic [2:0][7:0]      mag_next;
  logic [2:0]           step;
  logic                 busy;
  logic                 rnd;
  logic                 done;
  logic [7:0]           bitv;

  assign bitv = 8'h80 >> step;

  // one trial bit per channel, and the final rounding
  always_comb begin
    logic [7:0]  t;
    logic [15:0] tt;
    logic [16:0] rem;
    for (int c = 0; c < 3; c++) begin
      t  = r[c] | bitv;
      tt = t * t;
      r_next[c] = (tt <= sv[c]) ? t : r[c];
      tt  = r[c] * r[c];
      rem = {1'b0, sv[c]} - {1'b0, tt};
      if (sat[c]) begin
        mag_next[c] = 8'hFF;
      end else if (rem > {9'b0, r[c]}) begin
        mag_next[c] = r[c] + 8'd1;
      end else begin
        mag_next[c] = r[c];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
          rnd  <= 1'b1;
        end
      end else if (rnd) begin
        rnd  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (start) begin
        sat[c] <= sum[c] > SUM_W'(SQ_LIMIT);
        sv[c]  <= sum[c][SQ_W-1:0];
        r[c]   <= '0;
      end else if (busy) begin
        r[c] <= r_next[c];
      end else if (rnd) begin
        mag[c] <= mag_next[c];
      end
    end
  end

  assign res = '{done: done, mag: mag};

endmodule
`default_nettype wire

### src/sobel_edge_magnitude_rgb_unit.sv
// top level: line store sequencer, 3x3 window, sobel gradients and magnitude
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order.
// Pixel words enter on pix (pix_valid / pix_ready); result words leave on
// mag (mag_valid / mag_ready). Configuration is an APB port: image_width at
// address 0, image_height at address 4; any write restarts the frame.
// The result for pixel p leaves with input word p + width + 1, so after the
// last pixel of a frame the host sends width + 1 flush words (kind = 1).
// The last result of a frame carries frame_end.
// From acceptance to its result a word passes through line store read
// with window update, gradient, square sum, eight trial bits of the square
// root, a rounding step, a handoff step and the output register load, which
// waits for a free register; the sequencer then returns to idle for the next
// word. Words that give no result return to idle after the line store read.
// One word is processed at a time; the next word is accepted while a
// finished result still sits in the output register. When the receiver
// stalls, the next result waits in the sqrt unit until the register frees.
// Reset clears the window, the position counters and the control state and
// sets width 640, height 480; the line stores need no clearing since rows
// above the frame are masked.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  output logic                       pix_ready,
  input  wire sobel_pkg::sobel_in_t  pix,
  output logic                       mag_valid,
  input  wire logic                  mag_ready,
  output sobel_pkg::sobel_out_t      mag,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);
  import sobel_pkg::*;

  sobel_state_t state, state_next;
  sobel_cfg_t   cfg;
  sobel_sqrt_res_t sq_res;

  logic [COL_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_eff;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PIX_W-1:0] px_q;
  logic [PIX_W-1:0] win [9];
  logic [2*PIX_W-1:0] rdata;
  logic             mem_we;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  logic             have;
  logic [ROW_W-1:0] cr;
  logic [COL_W-1:0] cc;
  logic             emit;
  logic             m_top, m_bot, m_left, m_right, fend;
  logic [2:0][GRAD_W-1:0] gx, gy, gx_next, gy_next;
  logic [2:0][SUM_W-1:0]  sq_sum;
  logic             sq_start;
  logic             accept;
  logic             out_free;

  sobel_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  sobel_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(2*PIX_W)) u_ram (
    .clk(clk), .we(mem_we), .waddr(col_q[ADDR_W-1:0]), .wdata({mid, px_q}),
    .raddr(raddr), .rdata(rdata)
  );

  sobel_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .sum(sq_sum), .res(sq_res)
  );

  // effective frame size
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = COL_W'(1);
    end else if (cfg.image_width > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    h_eff = (cfg.image_height == '0) ? HGT_W'(1) : cfg.image_height;
  end

  assign pix_ready = (state == S_IDLE);
  assign accept    = pix_valid && pix_ready;
  assign out_free  = !mag_valid || mag_ready;
  assign col_eff   = (column_count >= w_eff) ? '0 : column_count;
  assign raddr     = col_eff[ADDR_W-1:0];
  assign top       = rdata[2*PIX_W-1:PIX_W];
  assign mid       = rdata[PIX_W-1:0];
  assign mem_we    = (state == S_READ);
  assign sq_start  = (state == S_SQ);

  // output decision for the window centered one row and one column back
  always_comb begin
    if (col_q != '0) begin
      have = row_q >= ROW_W'(1);
      cr   = row_q - ROW_W'(1);
      cc   = col_q - COL_W'(1);
    end else begin
      have = row_q >= ROW_W'(2);
      cr   = row_q - ROW_W'(2);
      cc   = w_eff - COL_W'(1);
    end
    emit = have && (cr < {1'b0, h_eff});
  end

  // gradients with taps outside the image masked to zero
  always_comb begin
    logic [7:0]        v [9];
    logic [GRAD_W-1:0] a, b;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        v[i] = win[i][8*(2-c) +: 8];
        if ((i / 3 == 0 && m_top) || (i / 3 == 2 && m_bot) ||
            (i % 3 == 0 && m_left) || (i % 3 == 2 && m_right)) begin
          v[i] = '0;
        end
      end
      a = GRAD_W'(v[2]) + {3'b0, v[5], 1'b0} + GRAD_W'(v[8]);
      b = GRAD_W'(v[0]) + {3'b0, v[3], 1'b0} + GRAD_W'(v[6]);
      gx_next[c] = a - b;
      a = GRAD_W'(v[6]) + {3'b0, v[7], 1'b0} + GRAD_W'(v[8]);
      b = GRAD_W'(v[0]) + {3'b0, v[1], 1'b0} + GRAD_W'(v[2]);
      gy_next[c] = a - b;
    end
  end

  // squared magnitude into the sqrt unit
  always_comb begin
    logic [2*GRAD_W-1:0] px2, py2;
    for (int c = 0; c < 3; c++) begin
      px2 = (2*GRAD_W)'($signed(gx[c]) * $signed(gx[c]));
      py2 = (2*GRAD_W)'($signed(gy[c]) * $signed(gy[c]));
      sq_sum[c] = SUM_W'(px2 + py2);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = emit ? S_GRAD : S_IDLE;
      S_GRAD: state_next = S_SQ;
      S_SQ:   state_next = S_SQRT;
      S_SQRT: if (sq_res.done) state_next = S_PUSH;
      S_PUSH: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // counters, window and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      mag_valid    <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      if (state == S_PUSH && out_free) begin
        mag_valid <= 1'b1;
      end else if (mag_valid && mag_ready) begin
        mag_valid <= 1'b0;
      end
      if (cfg.restart) begin
        column_count <= '0;
        row_count    <= '0;
        for (int i = 0; i < 9; i++) win[i] <= '0;
      end else begin
        case (state)
          S_READ: begin
            for (int r = 0; r < 3; r++) begin
              win[r*3]   <= win[r*3+1];
              win[r*3+1] <= win[r*3+2];
            end
            win[2] <= top;
            win[5] <= mid;
            win[8] <= px_q;
            if (col_q + COL_W'(1) >= w_eff) begin
              column_count <= '0;
              row_count    <= row_q + ROW_W'(1);
            end else begin
              column_count <= col_q + COL_W'(1);
              row_count    <= row_q;
            end
          end
          S_SQ: begin
            if (fend) begin
              column_count <= '0;
              row_count    <= '0;
              for (int i = 0; i < 9; i++) win[i] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_q  <= pix.kind ? '0 : {pix.red_in, pix.green_in, pix.blue_in};
      col_q <= col_eff;
      row_q <= row_count;
    end
    if (state == S_READ) begin
      m_top   <= cr == '0;
      m_bot   <= cr == {1'b0, h_eff - HGT_W'(1)};
      m_left  <= cc == '0;
      m_right <= cc == w_eff - COL_W'(1);
      fend    <= (cr == {1'b0, h_eff - HGT_W'(1)}) && (cc == w_eff - COL_W'(1));
    end
    if (state == S_GRAD) begin
      gx <= gx_next;
      gy <= gy_next;
    end
    if (state == S_PUSH && out_free) begin
      mag.red_edge   <= sq_res.mag[0];
      mag.green_edge <= sq_res.mag[1];
      mag.blue_edge  <= sq_res.mag[2];
      mag.frame_end  <= fend;
    end
  end

  // an accepted word always goes to the line store read next
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ) else $error("accept not followed by read");

  // the sqrt unit finishes only while the sequencer waits for it
  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sq_res.done |-> state == S_SQRT) else $error("sqrt done out of turn");

  // a new result is loaded only into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_free) |=> mag_valid) else $error("result lost");

endmodule
`default_nettype wire
